// ===== hw/rtl/dwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depthwise 3x3 stride-2 convolution package
// Shared constants, register codes and the structures passed between the
// blocks of the convolution core.
// ----------------------------------------------------------------------------
package dwc_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int HEIGHT_LIMIT = 2048;
   localparam int PIXEL_BITS   = 16;
   localparam int TAP_BITS     = 16;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = $clog2(HEIGHT_LIMIT);
   localparam int CMP_BITS = 14;

   localparam int IN_WIDTH_BITS   = 11;
   localparam int IN_HEIGHT_BITS  = 12;
   localparam int OUT_WIDTH_BITS  = 9;
   localparam int OUT_HEIGHT_BITS = 10;
   localparam int KROW_BITS       = 3 * TAP_BITS;

   localparam int PROD_BITS = PIXEL_BITS + TAP_BITS;
   localparam int RSUM_BITS = PROD_BITS + 2;
   localparam int SUM_BITS  = PROD_BITS + 4;
   localparam int CONV_BITS = 36;

   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 6;

   typedef enum logic [2:0] {
      REG_IN_WIDTH      = 3'd0,
      REG_IN_HEIGHT     = 3'd1,
      REG_OUT_WIDTH     = 3'd2,
      REG_OUT_HEIGHT    = 3'd3,
      REG_KERNEL_TOP    = 3'd4,
      REG_KERNEL_MID    = 3'd5,
      REG_KERNEL_BOTTOM = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [IN_WIDTH_BITS-1:0]      in_width;
      logic [IN_HEIGHT_BITS-1:0]     in_height;
      logic [OUT_WIDTH_BITS-1:0]     out_width;
      logic [OUT_HEIGHT_BITS-1:0]    out_height;
      logic [2:0][KROW_BITS-1:0]     kernel;
   } cfg_type;

   typedef struct packed {
      logic [COL_BITS-1:0] x;
      logic                hit;
      logic                done;
   } pos_type;

   typedef struct packed {
      logic [2:0][2:0][PIXEL_BITS-1:0] pix;
      logic                            done;
   } operand_type;

endpackage

// ===== hw/rtl/dwc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dwc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dwc_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the plane sizes and the kernel taps.
// ----------------------------------------------------------------------------
module dwc_csr
   import dwc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff;
   logic          wr_en;
   reg_index_type index;

   assign index = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:3]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_width   <= IN_WIDTH_BITS'(3);
         cfg_ff.in_height  <= IN_HEIGHT_BITS'(3);
         cfg_ff.out_width  <= OUT_WIDTH_BITS'(1);
         cfg_ff.out_height <= OUT_HEIGHT_BITS'(1);
         cfg_ff.kernel     <= '0;
      end else if (wr_en) begin
         unique case (index)
            REG_IN_WIDTH:      cfg_ff.in_width   <= csr_pwdata[IN_WIDTH_BITS-1:0];
            REG_IN_HEIGHT:     cfg_ff.in_height  <= csr_pwdata[IN_HEIGHT_BITS-1:0];
            REG_OUT_WIDTH:     cfg_ff.out_width  <= csr_pwdata[OUT_WIDTH_BITS-1:0];
            REG_OUT_HEIGHT:    cfg_ff.out_height <= csr_pwdata[OUT_HEIGHT_BITS-1:0];
            REG_KERNEL_TOP:    cfg_ff.kernel[0]  <= csr_pwdata[KROW_BITS-1:0];
            REG_KERNEL_MID:    cfg_ff.kernel[1]  <= csr_pwdata[KROW_BITS-1:0];
            REG_KERNEL_BOTTOM: cfg_ff.kernel[2]  <= csr_pwdata[KROW_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_IN_WIDTH:      csr_prdata = CSR_DATA_BITS'(cfg_ff.in_width);
         REG_IN_HEIGHT:     csr_prdata = CSR_DATA_BITS'(cfg_ff.in_height);
         REG_OUT_WIDTH:     csr_prdata = CSR_DATA_BITS'(cfg_ff.out_width);
         REG_OUT_HEIGHT:    csr_prdata = CSR_DATA_BITS'(cfg_ff.out_height);
         REG_KERNEL_TOP:    csr_prdata = CSR_DATA_BITS'(cfg_ff.kernel[0]);
         REG_KERNEL_MID:    csr_prdata = CSR_DATA_BITS'(cfg_ff.kernel[1]);
         REG_KERNEL_BOTTOM: csr_prdata = CSR_DATA_BITS'(cfg_ff.kernel[2]);
         default:           csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ===== hw/rtl/dwc_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster position tracker
// Column and row counters of the incoming pixel, with the decode of which
// pixels close an output window and which output ends the plane.
// ----------------------------------------------------------------------------
module dwc_scan
   import dwc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    step,
   output pos_type pos
);

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;

   logic [CMP_BITS-1:0] in_w, in_h, ew_m1, eh_m1, ow, oh, ow_lim, oh_lim;
   logic [CMP_BITS-1:0] x, y, ox, oy;

   always_comb begin
      in_w = CMP_BITS'(cfg.in_width);
      in_h = CMP_BITS'(cfg.in_height);

      if (in_w < CMP_BITS'(3)) begin
         ew_m1 = CMP_BITS'(2);
      end else if (in_w > CMP_BITS'(MAX_WIDTH)) begin
         ew_m1 = CMP_BITS'(MAX_WIDTH - 1);
      end else begin
         ew_m1 = in_w - CMP_BITS'(1);
      end

      if (in_h < CMP_BITS'(3)) begin
         eh_m1 = CMP_BITS'(2);
      end else if (in_h > CMP_BITS'(HEIGHT_LIMIT)) begin
         eh_m1 = CMP_BITS'(HEIGHT_LIMIT - 1);
      end else begin
         eh_m1 = in_h - CMP_BITS'(1);
      end

      ow_lim = ew_m1 >> 1;
      oh_lim = eh_m1 >> 1;
      ow = (CMP_BITS'(cfg.out_width) < ow_lim) ? CMP_BITS'(cfg.out_width) : ow_lim;
      oh = (CMP_BITS'(cfg.out_height) < oh_lim) ? CMP_BITS'(cfg.out_height) : oh_lim;

      x = (CMP_BITS'(col_ff) < ew_m1) ? CMP_BITS'(col_ff) : ew_m1;
      y = (CMP_BITS'(row_ff) < eh_m1) ? CMP_BITS'(row_ff) : eh_m1;
      ox = (x >> 1) - CMP_BITS'(1);
      oy = (y >> 1) - CMP_BITS'(1);

      pos.x    = x[COL_BITS-1:0];
      pos.hit  = (x >= CMP_BITS'(2)) && (y >= CMP_BITS'(2)) && !x[0] && !y[0]
                 && (ox < ow) && (oy < oh);
      pos.done = pos.hit && (ox == ow - CMP_BITS'(1)) && (oy == oh - CMP_BITS'(1));

      if (x >= ew_m1) begin
         col_in = '0;
         row_in = (y >= eh_m1) ? '0 : ROW_BITS'(y + CMP_BITS'(1));
      end else begin
         col_in = COL_BITS'(x + CMP_BITS'(1));
         row_in = y[ROW_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (step) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== hw/rtl/dwc_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window multiply-accumulate pipeline
// Operand register, nine tap products, three row sums and the result
// register, each stage with its own valid bit and back-pressure.
// ----------------------------------------------------------------------------
module dwc_mac
   import dwc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0][KROW_BITS-1:0] kernel,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  operand_type          in_op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CONV_BITS-1:0] rsp_conv_value,
   output logic                 rsp_plane_done
);

   logic        a_valid_ff, b_valid_ff, c_valid_ff, rsp_valid_ff;
   operand_type a_op_ff;
   logic        b_done_ff, c_done_ff, rsp_done_ff;

   logic signed [PROD_BITS-1:0] b_prod_ff [3][3];
   logic signed [PROD_BITS-1:0] b_prod_in [3][3];
   logic signed [RSUM_BITS-1:0] c_rsum_ff [3];
   logic signed [RSUM_BITS-1:0] c_rsum_in [3];
   logic signed [SUM_BITS-1:0]  sum_in;
   logic [CONV_BITS-1:0]        rsp_value_ff;

   logic out_free, c_ready, b_ready, a_ready;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign c_ready  = !c_valid_ff || out_free;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            b_prod_in[r][c] = $signed(a_op_ff.pix[r][c])
                              * $signed(kernel[r][c*TAP_BITS +: TAP_BITS]);
         end
      end
      for (int r = 0; r < 3; r++) begin
         c_rsum_in[r] = RSUM_BITS'(b_prod_ff[r][0]) + RSUM_BITS'(b_prod_ff[r][1])
                        + RSUM_BITS'(b_prod_ff[r][2]);
      end
      sum_in = SUM_BITS'(c_rsum_ff[0]) + SUM_BITS'(c_rsum_ff[1])
               + SUM_BITS'(c_rsum_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && a_ready) begin
         a_op_ff <= in_op;
      end
      if (a_valid_ff && b_ready) begin
         b_prod_ff <= b_prod_in;
         b_done_ff <= a_op_ff.done;
      end
      if (b_valid_ff && c_ready) begin
         c_rsum_ff <= c_rsum_in;
         c_done_ff <= b_done_ff;
      end
      if (c_valid_ff && out_free) begin
         rsp_value_ff <= CONV_BITS'(sum_in);
         rsp_done_ff  <= c_done_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_conv_value = rsp_value_ff;
   assign rsp_plane_done = rsp_done_ff;

endmodule

// ===== hw/rtl/depthwise_conv3x3_stride2_core.sv =====
`timescale 1ns / 1ps
// A closing pixel passes s1, then operand, product, row-sum and result registers.
// Throughput: one pixel per cycle; the input register and the line store ports
// take one pixel per clock, and the pipeline stalls only when the result waits.
// Reset (synchronous): clears the position counters and all valid bits; the
// line stores and window registers are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Depthwise 3x3 stride-2 convolution core
// Streams one channel plane in raster order through two line stores and a window of
// registers, and emits the 3x3 dot product of each stride-2 window the sizes allow.
// ----------------------------------------------------------------------------
module depthwise_conv3x3_stride2_core
   import dwc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [PIXEL_BITS-1:0]    req_pixel,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CONV_BITS-1:0]     rsp_conv_value,
   output logic                     rsp_plane_done,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type     cfg;
   pos_type     scan_pos;
   operand_type mac_op;
   logic        mac_ready;

   logic                  s1_valid_ff, s1_hit_ff, s1_done_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [COL_BITS-1:0]   s1_x_ff;
   logic [PIXEL_BITS-1:0] win_ff [6];

   logic                  accept, s1_adv;
   logic [PIXEL_BITS-1:0] top_pix, mid_pix;

   dwc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dwc_scan u_scan (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .step  (accept),
      .pos   (scan_pos)
   );

   assign s1_adv    = s1_valid_ff && (!s1_hit_ff || mac_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   dwc_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_upper (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_x_ff),
      .wr_data (mid_pix),
      .rd_en   (accept),
      .rd_addr (scan_pos.x),
      .rd_data (top_pix)
   );

   dwc_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_lower (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_x_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (accept),
      .rd_addr (scan_pos.x),
      .rd_data (mid_pix)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_x_ff     <= scan_pos.x;
         s1_hit_ff   <= scan_pos.hit;
         s1_done_ff  <= scan_pos.done;
      end
      if (s1_adv) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_pix;
         win_ff[4] <= mid_pix;
         win_ff[5] <= s1_pixel_ff;
      end
   end

   always_comb begin
      mac_op.pix[0][0] = win_ff[0];
      mac_op.pix[0][1] = win_ff[3];
      mac_op.pix[0][2] = top_pix;
      mac_op.pix[1][0] = win_ff[1];
      mac_op.pix[1][1] = win_ff[4];
      mac_op.pix[1][2] = mid_pix;
      mac_op.pix[2][0] = win_ff[2];
      mac_op.pix[2][1] = win_ff[5];
      mac_op.pix[2][2] = s1_pixel_ff;
      mac_op.done      = s1_done_ff;
   end

   dwc_mac u_mac (
      .clock          (clock),
      .reset          (reset),
      .kernel         (cfg.kernel),
      .in_valid       (s1_valid_ff && s1_hit_ff),
      .in_ready       (mac_ready),
      .in_op          (mac_op),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_conv_value (rsp_conv_value),
      .rsp_plane_done (rsp_plane_done)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (accept && s1_adv) |-> (scan_pos.x != s1_x_ff))
      else $error("Line store read and write collide on one column.");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_done_ff) |-> s1_hit_ff)
      else $error("Plane end flagged on a pixel that closes no window.");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_x_ff)
                                    && $stable(s1_pixel_ff)))
      else $error("Held pixel lost or changed while stalled.");

   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!s1_valid_ff && !rsp_valid))
      else $error("Pipeline not empty after reset.");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depthwise 3x3 stride-2 convolution core testbench
// Streams whole pixel planes through the core under random idling on both
// channels and checks every window sum and plane-end flag against a predictor
// that keeps its own line stores, window and position counters. Covers the
// extreme pixel and tap values, size clamping, planes without outputs,
// mid-plane register updates and long result stalls.
// ----------------------------------------------------------------------------
module testbench;
   import dwc_pkg::*;

   localparam int DRAIN_SLACK = 16;
   localparam int RANDOM_PIXELS = 30;

   typedef struct {
      logic [CONV_BITS-1:0] conv_value;
      logic                 plane_done;
   } conv_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [PIXEL_BITS-1:0]    req_pixel = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [CONV_BITS-1:0]     rsp_conv_value;
   logic                     rsp_plane_done;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   logic [IN_WIDTH_BITS-1:0]   cfg_in_width = 11'd3;
   logic [IN_HEIGHT_BITS-1:0]  cfg_in_height = 12'd3;
   logic [OUT_WIDTH_BITS-1:0]  cfg_out_width = 9'd1;
   logic [OUT_HEIGHT_BITS-1:0] cfg_out_height = 10'd1;
   logic [KROW_BITS-1:0]       cfg_kernel [3] = '{default: '0};

   logic [PIXEL_BITS-1:0] upper_line [MAX_WIDTH] = '{default: '0};
   logic [PIXEL_BITS-1:0] lower_line [MAX_WIDTH] = '{default: '0};
   logic [PIXEL_BITS-1:0] window [6] = '{default: '0};
   int unsigned           col_pos = 0;
   int unsigned           row_pos = 0;

   conv_result_type pending_convs [$];

   int unsigned mismatch_count = 0;
   int unsigned pixels_sent = 0;
   int unsigned results_seen = 0;
   int unsigned plane_ends = 0;
   int unsigned register_writes = 0;
   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   int unsigned hold_len = 0;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;

   depthwise_conv3x3_stride2_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_conv_value (rsp_conv_value),
      .rsp_plane_done (rsp_plane_done),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void log_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch: %s", msg);
      end
   endfunction

   function automatic int unsigned clamp_size(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int unsigned eff_width();
      return clamp_size(32'(cfg_in_width), 3, MAX_WIDTH);
   endfunction

   function automatic int unsigned eff_height();
      return clamp_size(32'(cfg_in_height), 3, HEIGHT_LIMIT);
   endfunction

   function automatic longint tap_at(logic [KROW_BITS-1:0] krow, int k);
      return longint'($signed(krow[k*TAP_BITS +: TAP_BITS]));
   endfunction

   function automatic longint row_dot(logic [KROW_BITS-1:0] krow, logic [PIXEL_BITS-1:0] a,
                                      logic [PIXEL_BITS-1:0] b, logic [PIXEL_BITS-1:0] c);
      return longint'($signed(a)) * tap_at(krow, 0) + longint'($signed(b)) * tap_at(krow, 1)
           + longint'($signed(c)) * tap_at(krow, 2);
   endfunction

   // Advances the window by one pixel and queues the sum of a window that it closes.
   function automatic void slide_window(logic [PIXEL_BITS-1:0] px);
      int unsigned     ew, eh, ow, oh, x, y, ox, oy;
      logic [PIXEL_BITS-1:0] top, mid;
      longint          sum;
      conv_result_type res;
      ew = eff_width();
      eh = eff_height();
      ow = (cfg_out_width < (ew - 1) / 2) ? cfg_out_width : (ew - 1) / 2;
      oh = (cfg_out_height < (eh - 1) / 2) ? cfg_out_height : (eh - 1) / 2;
      x = (col_pos < ew - 1) ? col_pos : ew - 1;
      y = (row_pos < eh - 1) ? row_pos : eh - 1;
      top = upper_line[COL_BITS'(x)];
      mid = lower_line[COL_BITS'(x)];
      if (x >= 2 && y >= 2 && x % 2 == 0 && y % 2 == 0) begin
         ox = (x - 2) / 2;
         oy = (y - 2) / 2;
         if (ox < ow && oy < oh) begin
            sum = row_dot(cfg_kernel[0], window[0], window[3], top)
                + row_dot(cfg_kernel[1], window[1], window[4], mid)
                + row_dot(cfg_kernel[2], window[2], window[5], px);
            res.conv_value = sum[CONV_BITS-1:0];
            res.plane_done = (ox == ow - 1 && oy == oh - 1);
            if (res.plane_done) begin
               plane_ends++;
            end
            pending_convs.push_back(res);
         end
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = top;
      window[4] = mid;
      window[5] = px;
      upper_line[COL_BITS'(x)] = mid;
      lower_line[COL_BITS'(x)] = px;
      if (x >= ew - 1) begin
         col_pos = 0;
         row_pos = (y >= eh - 1) ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
         row_pos = y;
      end
   endfunction

   function automatic int unsigned pick_gap();
      return ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   function automatic int unsigned idle_choice();
      int unsigned r;
      r = $urandom_range(0, 2);
      return (r == 0) ? 0 : ((r == 1) ? 10 : 30);
   endfunction

   function automatic logic [PIXEL_BITS-1:0] random_pixel();
      int unsigned r;
      r = $urandom_range(0, 19);
      case (r)
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         default: return PIXEL_BITS'($urandom());
      endcase
   endfunction

   function automatic logic [KROW_BITS-1:0] random_krow();
      logic [KROW_BITS-1:0] krow;
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(0, 9))
            0: krow[k*TAP_BITS +: TAP_BITS] = 16'h8000;
            1: krow[k*TAP_BITS +: TAP_BITS] = 16'h7FFF;
            default: krow[k*TAP_BITS +: TAP_BITS] = TAP_BITS'($urandom());
         endcase
      end
      return krow;
   endfunction

   // Result side: random stalls, plus a long hold-off when a test asks for one.
   always @(posedge clock) begin
      if (hold_len != 0) begin
         hold_left = hold_len;
         hold_len = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
         stall_left = pick_gap() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      conv_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_convs.size() == 0) begin
            log_mismatch($sformatf("unexpected result conv_value %0d plane_done %0b",
                                   $signed(rsp_conv_value), rsp_plane_done));
         end else begin
            want = pending_convs.pop_front();
            if (rsp_conv_value !== want.conv_value) begin
               log_mismatch($sformatf("conv_value expected %0d actual %0d",
                                      $signed(want.conv_value), $signed(rsp_conv_value)));
            end
            if (rsp_plane_done !== want.plane_done) begin
               log_mismatch($sformatf("plane_done expected %0b actual %0b",
                                      want.plane_done, rsp_plane_done));
            end
         end
      end
   end

   task automatic send_pixel(logic [PIXEL_BITS-1:0] px);
      int unsigned gap;
      gap = (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (!req_ready);
      slide_window(px);
      pixels_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_convs.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] want;
      case (idx)
         REG_IN_WIDTH: begin
            cfg_in_width = value[IN_WIDTH_BITS-1:0];
            want = CSR_DATA_BITS'(cfg_in_width);
         end
         REG_IN_HEIGHT: begin
            cfg_in_height = value[IN_HEIGHT_BITS-1:0];
            want = CSR_DATA_BITS'(cfg_in_height);
         end
         REG_OUT_WIDTH: begin
            cfg_out_width = value[OUT_WIDTH_BITS-1:0];
            want = CSR_DATA_BITS'(cfg_out_width);
         end
         REG_OUT_HEIGHT: begin
            cfg_out_height = value[OUT_HEIGHT_BITS-1:0];
            want = CSR_DATA_BITS'(cfg_out_height);
         end
         REG_KERNEL_TOP: begin
            cfg_kernel[0] = value[KROW_BITS-1:0];
            want = CSR_DATA_BITS'(cfg_kernel[0]);
         end
         REG_KERNEL_MID: begin
            cfg_kernel[1] = value[KROW_BITS-1:0];
            want = CSR_DATA_BITS'(cfg_kernel[1]);
         end
         REG_KERNEL_BOTTOM: begin
            cfg_kernel[2] = value[KROW_BITS-1:0];
            want = CSR_DATA_BITS'(cfg_kernel[2]);
         end
         default: begin
            want = '0;
         end
      endcase
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         log_mismatch($sformatf("register %s read back %0h, expected %0h",
                                idx.name(), csr_prdata, want));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      register_writes++;
   endtask

   task automatic set_geometry(int unsigned iw, int unsigned ih, int unsigned ow,
                               int unsigned oh);
      csr_write(REG_IN_WIDTH, CSR_DATA_BITS'(iw));
      csr_write(REG_IN_HEIGHT, CSR_DATA_BITS'(ih));
      csr_write(REG_OUT_WIDTH, CSR_DATA_BITS'(ow));
      csr_write(REG_OUT_HEIGHT, CSR_DATA_BITS'(oh));
   endtask

   task automatic set_kernel(logic [KROW_BITS-1:0] top, logic [KROW_BITS-1:0] mid,
                             logic [KROW_BITS-1:0] bottom);
      csr_write(REG_KERNEL_TOP, CSR_DATA_BITS'(top));
      csr_write(REG_KERNEL_MID, CSR_DATA_BITS'(mid));
      csr_write(REG_KERNEL_BOTTOM, CSR_DATA_BITS'(bottom));
   endtask

   task automatic run_planes(int unsigned iw, int unsigned ih, int unsigned ow,
                             int unsigned oh, int unsigned planes);
      int unsigned count;
      set_geometry(iw, ih, ow, oh);
      count = planes * eff_width() * eff_height();
      repeat (count) send_pixel(random_pixel());
      wait_idle();
   endtask

   task automatic test_reset_defaults();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      repeat (9) send_pixel(random_pixel());
      wait_idle();
   endtask

   task automatic test_directed_values();
      logic [PIXEL_BITS-1:0] img [25];
      img = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
              16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 16'h0100,
              16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFF00,
              16'h1234, 16'hEDCB, 16'h7FFF, 16'h8000, 16'h0001,
              16'hFFFF, 16'h0000, 16'h8001, 16'h7FFE, 16'h8000};
      tx_idle_pct = 30;
      rx_idle_pct = 30;
      set_geometry(5, 5, 2, 2);
      set_kernel(48'h7FFF_8000_0001, 48'hFFFF_4000_8000, 48'h0000_7FFF_C000);
      foreach (img[i]) send_pixel(img[i]);
      wait_idle();
      // Largest positive and largest negative window sums.
      set_geometry(3, 3, 1, 1);
      set_kernel(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
      repeat (9) send_pixel(16'h8000);
      repeat (9) send_pixel(16'h7FFF);
      wait_idle();
   endtask

   task automatic test_size_limits();
      tx_idle_pct = 10;
      rx_idle_pct = 10;
      set_kernel(48'hFFFF_FFFF_FFFF, 48'h0, random_krow());
      run_planes(0, 0, 511, 1023, 1);
      run_planes(1, 2, 511, 1023, 1);
      run_planes(2, 1, 0, 0, 1);
      set_kernel(random_krow(), random_krow(), random_krow());
      run_planes(5, 5, 0, 2, 1);
      run_planes(5, 5, 2, 0, 1);
      run_planes(9, 5, 2, 1, 2);
   endtask

   task automatic test_mid_plane_updates();
      tx_idle_pct = 20;
      rx_idle_pct = 20;
      set_kernel(random_krow(), random_krow(), random_krow());
      set_geometry(7, 7, 3, 3);
      repeat (21) send_pixel(random_pixel());
      wait_idle();
      set_kernel(random_krow(), random_krow(), random_krow());
      csr_write(REG_OUT_WIDTH, CSR_DATA_BITS'(2));
      repeat (28) send_pixel(random_pixel());
      wait_idle();
      // Shrinking the height below the current row ends the plane on that row.
      set_geometry(5, 7, 2, 3);
      repeat (35 + 25) send_pixel(random_pixel());
      wait_idle();
      csr_write(REG_IN_HEIGHT, CSR_DATA_BITS'(5));
      repeat (5 + 25) send_pixel(random_pixel());
      wait_idle();
   endtask

   task automatic test_backpressure();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_kernel(random_krow(), random_krow(), random_krow());
      set_geometry(9, 7, 4, 3);
      hold_len = 300;
      repeat (63) send_pixel(random_pixel());
      wait_idle();
   endtask

   task automatic test_random_planes();
      int unsigned start, iw, ih, mw, mh, ow, oh, r;
      start = pixels_sent;
      while (pixels_sent - start < RANDOM_PIXELS) begin
         iw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 11);
         ih = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9) : $urandom_range(3, 7);
         mw = (clamp_size(iw, 3, MAX_WIDTH) - 1) / 2;
         mh = (clamp_size(ih, 3, HEIGHT_LIMIT) - 1) / 2;
         r = $urandom_range(0, 9);
         ow = (r < 7) ? mw : ((r < 9) ? $urandom_range(0, mw) : $urandom_range(0, 511));
         r = $urandom_range(0, 9);
         oh = (r < 7) ? mh : ((r < 9) ? $urandom_range(0, mh) : $urandom_range(0, 1023));
         tx_idle_pct = idle_choice();
         rx_idle_pct = idle_choice();
         set_kernel(random_krow(), random_krow(), random_krow());
         run_planes(iw, ih, ow, oh, $urandom_range(1, 2));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_values();
      test_size_limits();
      test_mid_plane_updates();
      test_backpressure();
      test_random_planes();
      wait_idle();
      if (pending_convs.size() != 0) begin
         log_mismatch($sformatf("%0d results never arrived", pending_convs.size()));
      end
      $display("summary: %0d pixels sent, %0d results checked, %0d plane ends, %0d register writes",
               pixels_sent, results_seen, plane_ends, register_writes);
      $display("summary: size clamping, empty planes, mid-plane updates and long stalls covered");
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== depthwise_conv3x3_stride2_core.f =====
hw/rtl/dwc_pkg.sv
hw/rtl/dwc_ram.sv
hw/rtl/dwc_csr.sv
hw/rtl/dwc_scan.sv
hw/rtl/dwc_mac.sv
hw/rtl/depthwise_conv3x3_stride2_core.sv
bench/testbench.sv
